/* sv/s2i64_pkg.sv */
// ----------------------------------------------------------------------------
// s2i64_pkg: shared types and constants of the string to int64 parser
// Character, result and status types, the parse phases, and the
// character classification helpers.
// ----------------------------------------------------------------------------
package s2i64_pkg;

  typedef logic [7:0]         char_t;
  typedef logic [5:0]         base_t;
  typedef logic signed [63:0] value_t;
  typedef logic [15:0]        offset_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_CONVERTED = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_RANGE     = 2'd2,
    ST_BAD_BASE  = 2'd3
  } status_t;

  // parse phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_LEAD       = 6'b000010,
    PH_AFTER_SIGN = 6'b000100,
    PH_ZERO       = 6'b001000,
    PH_HEXSTART   = 6'b010000,
    PH_DIGITS     = 6'b100000
  } phase_t;

  localparam base_t  MAX_BASE  = 6'd36;
  localparam base_t  HEX_BASE  = 6'd16;
  localparam base_t  OCT_BASE  = 6'd8;
  localparam base_t  DEC_BASE  = 6'd10;
  localparam base_t  NOT_DIGIT = 6'd63;
  localparam value_t INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam value_t INT64_MIN = 64'sh8000_0000_0000_0000;

  // digit worth of a character: 0-9, A-Z / a-z worth 10..35, else NOT_DIGIT
  function automatic base_t digit_value(input char_t c);
    char_t u;
    u = c;
    if (c inside {["a":"z"]}) begin
      u = c - 8'd32;
    end
    if (c inside {["0":"9"]}) begin
      return 6'(c - "0");
    end else if (u inside {["A":"Z"]}) begin
      return 6'(u - "A") + 6'd10;
    end else begin
      return NOT_DIGIT;
    end
  endfunction

  // C-locale whitespace: space, TAB, LF, VT, FF, CR
  function automatic logic is_space(input char_t c);
    return (c == " ") || (c inside {[8'd9:8'd13]});
  endfunction

endpackage

/* sv/s2i64_if.sv */
// ----------------------------------------------------------------------------
// s2i64 channel interfaces
// Valid/ready channels for characters, results and the base register.
// ----------------------------------------------------------------------------
interface s2i64_char_if import s2i64_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t ch;
  logic  start_req;
  modport source(output valid, ch, start_req, input ready);
  modport sink(input valid, ch, start_req, output ready);
endinterface

interface s2i64_result_if import s2i64_pkg::*; ();
  logic    valid;
  logic    ready;
  value_t  value;
  status_t status;
  offset_t end_offset;
  modport source(output valid, value, status, end_offset, input ready);
  modport sink(input valid, value, status, end_offset, output ready);
endinterface

interface s2i64_cfg_if import s2i64_pkg::*; ();
  logic  valid;
  logic  ready;
  base_t number_base;
  modport source(output valid, number_base, input ready);
  modport sink(input valid, number_base, output ready);
endinterface

/* sv/string_to_int64_parser.sv */
// ----------------------------------------------------------------------------
// string_to_int64_parser: streaming strtoll, one character per transfer
// Skips whitespace, takes a sign, handles 0x / octal prefixes, accumulates
// digits with overflow detection and emits one saturated result per string.
// ----------------------------------------------------------------------------
//
//  channel  role    payload
//  -------  ------  -----------------------------------------------
//  chars    sink    ch[7:0], start_req
//  result   source  value[63:0] signed, status[1:0], end_offset[15:0]
//  cfg      sink    number_base[5:0] (always ready)
//
// One character per cycle sustained while no held result stalls the flow; the result for
// the character that ends the string passes the input register, then the result register.
// The per-character path is one 64x6 multiply-add and a carry check.
// A held result only blocks the character in the input register; chars.ready
// stays high while that register is empty or can move on.
// rst (synchronous) sets the phase to idle and number_base to 10.
// ----------------------------------------------------------------------------
module string_to_int64_parser import s2i64_pkg::*; #(
  parameter int unsigned LENGTH_LIMIT = 65535
) (
  input  logic             clk,
  input  logic             rst,
  s2i64_char_if.sink       chars,
  s2i64_result_if.source   result,
  s2i64_cfg_if.sink        cfg
);

  localparam offset_t COUNT_CAP =
    (LENGTH_LIMIT < 32'd65535) ? 16'(LENGTH_LIMIT) : 16'hFFFF;

  // configuration register
  base_t number_base;

  // input register
  logic  s_valid;
  char_t s_ch;
  logic  s_start;

  // parse state
  phase_t  phase, phase_next;
  logic    negative, negative_next;
  logic [63:0] accumulator, accumulator_next;
  logic    overflowed, overflowed_next;
  base_t   effective_base, effective_base_next;
  offset_t char_count, char_count_next;
  logic    have_digits, have_digits_next;
  offset_t prefix_offset, prefix_offset_next;

  // result of the item in the input register
  logic    res_emit;
  value_t  res_value;
  status_t res_status;
  offset_t res_offset;

  // result register
  logic    r_valid;
  value_t  r_value;
  status_t r_status;
  offset_t r_offset;

  logic advance;
  logic process;
  logic do_after_sign;
  logic do_digit;
  logic range_ovf;
  base_t dig;
  logic [69:0] mul;
  logic [70:0] mac;

  assign advance     = !r_valid || result.ready;
  assign process     = s_valid && advance;
  assign chars.ready = !s_valid || advance;
  assign cfg.ready   = 1'b1;

  // base register
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= DEC_BASE;
    end else if (cfg.valid && cfg.ready) begin
      number_base <= cfg.number_base;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (chars.ready) begin
      s_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s_ch    <= chars.ch;
      s_start <= chars.start_req;
    end
  end

  // per-character parse step
  always_comb begin
    phase_next          = phase;
    negative_next       = negative;
    accumulator_next    = accumulator;
    overflowed_next     = overflowed;
    effective_base_next = effective_base;
    char_count_next     = char_count;
    have_digits_next    = have_digits;
    prefix_offset_next  = prefix_offset;
    res_emit            = 1'b0;
    res_value           = '0;
    res_status          = ST_CONVERTED;
    res_offset          = '0;
    do_after_sign       = 1'b0;
    do_digit            = 1'b0;
    range_ovf           = 1'b0;
    dig                 = digit_value(s_ch);
    mul                 = '0;
    mac                 = '0;

    // a start opens a fresh string
    if (s_start) begin
      negative_next       = 1'b0;
      accumulator_next    = '0;
      overflowed_next     = 1'b0;
      char_count_next     = '0;
      have_digits_next    = 1'b0;
      prefix_offset_next  = '0;
      effective_base_next = number_base;
      phase_next          = PH_LEAD;
    end

    if (s_start && (number_base == 6'd1 || number_base > MAX_BASE)) begin
      res_emit   = 1'b1;
      res_status = ST_BAD_BASE;
      phase_next = PH_IDLE;
    end else begin
      case (phase_next)
        PH_LEAD: begin
          if (is_space(s_ch)) begin
            if (char_count_next < COUNT_CAP) char_count_next = char_count_next + 16'd1;
          end else if (s_ch == "+" || s_ch == "-") begin
            negative_next = (s_ch == "-");
            if (char_count_next < COUNT_CAP) char_count_next = char_count_next + 16'd1;
            phase_next = PH_AFTER_SIGN;
          end else begin
            do_after_sign = 1'b1;
          end
        end
        PH_AFTER_SIGN: do_after_sign = 1'b1;
        PH_ZERO: begin
          if (s_ch == "x" || s_ch == "X") begin
            prefix_offset_next = char_count_next;
            if (char_count_next < COUNT_CAP) char_count_next = char_count_next + 16'd1;
            effective_base_next = HEX_BASE;
            phase_next          = PH_HEXSTART;
          end else begin
            if (effective_base_next == '0) effective_base_next = OCT_BASE;
            accumulator_next = '0;
            have_digits_next = 1'b1;
            do_digit         = 1'b1;
          end
        end
        PH_HEXSTART: begin
          if (dig < HEX_BASE) begin
            do_digit = 1'b1;
          end else begin
            // lone 0x: the 0 counts as consumed
            res_emit   = 1'b1;
            res_offset = prefix_offset_next;
            phase_next = PH_IDLE;
          end
        end
        PH_DIGITS: do_digit = 1'b1;
        default: ;
      endcase

      // sign seen or skipped: look for a prefix zero
      if (do_after_sign) begin
        if (s_ch == "0" && (effective_base_next == '0 || effective_base_next == HEX_BASE)) begin
          prefix_offset_next = char_count_next;
          if (char_count_next < COUNT_CAP) char_count_next = char_count_next + 16'd1;
          phase_next = PH_ZERO;
        end else begin
          if (effective_base_next == '0) effective_base_next = DEC_BASE;
          do_digit = 1'b1;
        end
      end

      // digit accumulate, or finish on the first non-digit
      if (do_digit) begin
        phase_next = PH_DIGITS;
        if (effective_base_next < 6'd2 || dig >= effective_base_next) begin
          res_emit   = 1'b1;
          phase_next = PH_IDLE;
          range_ovf  = overflowed_next ||
                       (negative_next ? (accumulator_next > 64'h8000_0000_0000_0000)
                                      : accumulator_next[63]);
          if (!have_digits_next) begin
            res_status = ST_NO_DIGITS;
          end else if (range_ovf) begin
            res_status = ST_RANGE;
            res_value  = negative_next ? INT64_MIN : INT64_MAX;
            res_offset = char_count_next;
          end else begin
            res_value  = negative_next ? value_t'(64'd0 - accumulator_next)
                                       : value_t'(accumulator_next);
            res_offset = char_count_next;
          end
        end else begin
          mul = {6'd0, accumulator_next} * {64'd0, effective_base_next};
          mac = {1'b0, mul} + 71'(dig);
          // carry out of 64 bits means the value passed UINT64_MAX
          if (mac[70:64] != '0) begin
            overflowed_next = 1'b1;
          end else begin
            accumulator_next = mac[63:0];
          end
          have_digits_next = 1'b1;
          if (char_count_next < COUNT_CAP) char_count_next = char_count_next + 16'd1;
        end
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      negative       <= 1'b0;
      accumulator    <= '0;
      overflowed     <= 1'b0;
      effective_base <= '0;
      char_count     <= '0;
      have_digits    <= 1'b0;
      prefix_offset  <= '0;
    end else if (process) begin
      phase          <= phase_next;
      negative       <= negative_next;
      accumulator    <= accumulator_next;
      overflowed     <= overflowed_next;
      effective_base <= effective_base_next;
      char_count     <= char_count_next;
      have_digits    <= have_digits_next;
      prefix_offset  <= prefix_offset_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= s_valid && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && res_emit) begin
      r_value  <= res_value;
      r_status <= res_status;
      r_offset <= res_offset;
    end
  end

  assign result.valid      = r_valid;
  assign result.value      = r_value;
  assign result.status     = r_status;
  assign result.end_offset = r_offset;

  // checks
  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    (process && res_emit) |=> (phase == PH_IDLE))
    else $error("phase not idle after a result");

  a_bad_base_zero: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_status == ST_BAD_BASE) |-> (r_value == '0 && r_offset == '0))
    else $error("invalid base result not zero");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_status == ST_NO_DIGITS) |-> (r_value == '0 && r_offset == '0))
    else $error("no-digit result not zero");

  a_ovf_has_digits: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> have_digits)
    else $error("overflow without digits");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !advance) |=> (s_valid && $stable(s_ch) && $stable(s_start)))
    else $error("input register lost a stalled character");

endmodule
